>>> rtl/core/psd_pkg.sv
package psd_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int DIST_BITS  = 25;

    // difference, product and sum widths
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int LW = PW;
    // radicand (quotient) width and numerator width
    localparam int QB = 2 * DIST_BITS;
    localparam int NW = 2 * LW + 2 * FRAC_BITS;
    localparam int RW = LW + 1;

    localparam logic [1:0] REGION_START    = 2'd0;
    localparam logic [1:0] REGION_INTERIOR = 2'd1;
    localparam logic [1:0] REGION_END      = 2'd2;

    typedef logic signed [DW-1:0] diff_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;

endpackage

>>> rtl/core/point_segment_distance.sv
// Point to segment distance, fully pipelined: one word is taken in every cycle
// (busy stays low) and its result appears with done high at the end of the
// pipeline. The restoring divider (one quotient bit per stage) and the square
// root (one root bit per stage) follow six stages of differences, products,
// sums, selection, numerator and divider entry. The receiver cannot stall, and
// no word is ever dropped.
module point_segment_distance (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [psd_pkg::COORD_BITS-1:0] seg_start_x,
    input  logic [psd_pkg::COORD_BITS-1:0] seg_start_y,
    input  logic [psd_pkg::COORD_BITS-1:0] seg_end_x,
    input  logic [psd_pkg::COORD_BITS-1:0] seg_end_y,
    input  logic [psd_pkg::COORD_BITS-1:0] point_x,
    input  logic [psd_pkg::COORD_BITS-1:0] point_y,
    output logic                           done,
    output logic [psd_pkg::DIST_BITS-1:0]  distance,
    output logic [1:0]                     region,
    output logic                           zero_length
);
    import psd_pkg::*;

    localparam int LAT = 6 + QB + DIST_BITS;

    // stage A: differences
    logic  va_reg;
    diff_t abx_reg, aby_reg, apx_reg, apy_reg, epx_reg, epy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else
            va_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        abx_reg <= DW'($signed(seg_end_x)) - DW'($signed(seg_start_x));
        aby_reg <= DW'($signed(seg_end_y)) - DW'($signed(seg_start_y));
        apx_reg <= DW'($signed(point_x)) - DW'($signed(seg_start_x));
        apy_reg <= DW'($signed(point_y)) - DW'($signed(seg_start_y));
        epx_reg <= DW'($signed(point_x)) - DW'($signed(seg_end_x));
        epy_reg <= DW'($signed(point_y)) - DW'($signed(seg_end_y));
    end

    // stage B: products
    logic  vb_reg;
    prod_t p1_reg, p2_reg, l1_reg, l2_reg, c1_reg, c2_reg;
    prod_t s1_reg, s2_reg, e1_reg, e2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else
            vb_reg <= va_reg;
    end

    always_ff @(posedge clk)
    begin
        p1_reg <= PW'(apx_reg) * PW'(abx_reg);
        p2_reg <= PW'(apy_reg) * PW'(aby_reg);
        l1_reg <= PW'(abx_reg) * PW'(abx_reg);
        l2_reg <= PW'(aby_reg) * PW'(aby_reg);
        c1_reg <= PW'(apx_reg) * PW'(aby_reg);
        c2_reg <= PW'(apy_reg) * PW'(abx_reg);
        s1_reg <= PW'(apx_reg) * PW'(apx_reg);
        s2_reg <= PW'(apy_reg) * PW'(apy_reg);
        e1_reg <= PW'(epx_reg) * PW'(epx_reg);
        e2_reg <= PW'(epy_reg) * PW'(epy_reg);
    end

    // stage C: sums
    logic          vc_reg;
    sum_t          dot_reg, cross_reg;
    logic [LW-1:0] len2_reg, ds_reg, de_reg;
    sum_t          len2_s, ds_s, de_s;

    always_comb
    begin
        len2_s = SW'(l1_reg) + SW'(l2_reg);
        ds_s   = SW'(s1_reg) + SW'(s2_reg);
        de_s   = SW'(e1_reg) + SW'(e2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else
            vc_reg <= vb_reg;
    end

    always_ff @(posedge clk)
    begin
        dot_reg   <= SW'(p1_reg) + SW'(p2_reg);
        cross_reg <= SW'(c1_reg) - SW'(c2_reg);
        len2_reg  <= LW'(len2_s);
        ds_reg    <= LW'(ds_s);
        de_reg    <= LW'(de_s);
    end

    // stage D: region decision, cross magnitude, endpoint select
    logic          vd_reg;
    logic [1:0]    rgn_d_reg;
    logic          zero_d_reg;
    logic [LW-1:0] len2_d_reg, cmag_reg, d2_reg;
    logic [1:0]    rgn_next;
    logic          zero_next;
    sum_t          len2_ext;

    always_comb
    begin
        len2_ext  = SW'({1'b0, len2_reg});
        zero_next = (len2_reg == '0);
        if (zero_next || dot_reg <= 0)
            rgn_next = REGION_START;
        else if (dot_reg >= len2_ext)
            rgn_next = REGION_END;
        else
            rgn_next = REGION_INTERIOR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else
            vd_reg <= vc_reg;
    end

    always_ff @(posedge clk)
    begin
        rgn_d_reg  <= rgn_next;
        zero_d_reg <= zero_next;
        len2_d_reg <= len2_reg;
        cmag_reg   <= LW'(cross_reg < 0 ? -cross_reg : cross_reg);
        d2_reg     <= (rgn_next == REGION_END) ? de_reg : ds_reg;
    end

    // stage E: numerator and denominator
    logic          ve_reg;
    logic [1:0]    rgn_e_reg;
    logic          zero_e_reg;
    logic [NW-1:0] num_reg;
    logic [LW-1:0] den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else
            ve_reg <= vd_reg;
    end

    always_ff @(posedge clk)
    begin
        rgn_e_reg  <= rgn_d_reg;
        zero_e_reg <= zero_d_reg;
        if (rgn_d_reg == REGION_INTERIOR)
        begin
            num_reg <= (NW'(cmag_reg) * NW'(cmag_reg)) << (2 * FRAC_BITS);
            den_reg <= len2_d_reg;
        end
        else
        begin
            num_reg <= NW'(d2_reg) << (2 * FRAC_BITS);
            den_reg <= LW'(1);
        end
    end

    // divider stage arrays
    logic             vq_reg   [QB+1];
    logic [1:0]       rgn_q_reg[QB+1];
    logic             zero_q_reg[QB+1];
    logic             ovf_q_reg[QB+1];
    logic [RW-1:0]    rem_q_reg[QB+1];
    logic [QB-1:0]    nlo_q_reg[QB+1];
    logic [LW-1:0]    den_q_reg[QB+1];

    // stage F: divider entry, overflow check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vq_reg[0] <= 1'b0;
        else
            vq_reg[0] <= ve_reg;
    end

    always_ff @(posedge clk)
    begin
        rgn_q_reg[0]  <= rgn_e_reg;
        zero_q_reg[0] <= zero_e_reg;
        ovf_q_reg[0]  <= (num_reg >> QB) >= NW'(den_reg);
        rem_q_reg[0]  <= RW'(num_reg >> QB);
        nlo_q_reg[0]  <= num_reg[QB-1:0];
        den_q_reg[0]  <= den_reg;
    end

    genvar k;
    generate
        for (k = 0; k < QB; k++)
        begin : g_div
            logic [RW-1:0] sh;
            logic          ge;

            always_comb
            begin
                sh = {rem_q_reg[k][RW-2:0], nlo_q_reg[k][QB-1]};
                ge = sh >= {1'b0, den_q_reg[k]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vq_reg[k+1] <= 1'b0;
                else
                    vq_reg[k+1] <= vq_reg[k];
            end

            // shift the quotient bit in where the numerator bit left
            always_ff @(posedge clk)
            begin
                rgn_q_reg[k+1]  <= rgn_q_reg[k];
                zero_q_reg[k+1] <= zero_q_reg[k];
                ovf_q_reg[k+1]  <= ovf_q_reg[k];
                den_q_reg[k+1]  <= den_q_reg[k];
                rem_q_reg[k+1]  <= ge ? sh - {1'b0, den_q_reg[k]} : sh;
                nlo_q_reg[k+1]  <= {nlo_q_reg[k][QB-2:0], ge};
            end
        end
    endgenerate

    logic                 vs_reg   [1:DIST_BITS];
    logic [1:0]           rgn_s_reg[1:DIST_BITS];
    logic                 zero_s_reg[1:DIST_BITS];
    logic                 ovf_s_reg[1:DIST_BITS];
    logic [QB-1:0]        x_s_reg  [1:DIST_BITS];
    logic [DIST_BITS-1:0] r_s_reg  [1:DIST_BITS];

    genvar j;
    generate
        for (j = 0; j < DIST_BITS; j++)
        begin : g_root
            localparam int B = DIST_BITS - 1 - j;
            logic                 v_in;
            logic [1:0]           rgn_in;
            logic                 zero_in;
            logic                 ovf_in;
            logic [QB-1:0]        x_in;
            logic [DIST_BITS-1:0] r_in;
            logic [QB-1:0]        t;
            logic                 take;

            // the first root stage takes the quotient straight from the divider
            if (j == 0)
            begin : g_first
                assign v_in    = vq_reg[QB];
                assign rgn_in  = rgn_q_reg[QB];
                assign zero_in = zero_q_reg[QB];
                assign ovf_in  = ovf_q_reg[QB];
                assign x_in    = nlo_q_reg[QB];
                assign r_in    = '0;
            end
            else
            begin : g_next
                assign v_in    = vs_reg[j];
                assign rgn_in  = rgn_s_reg[j];
                assign zero_in = zero_s_reg[j];
                assign ovf_in  = ovf_s_reg[j];
                assign x_in    = x_s_reg[j];
                assign r_in    = r_s_reg[j];
            end

            // (r + 2^B)^2 - r^2, compared with what is left of the radicand
            always_comb
            begin
                t    = (QB'(r_in) << (B + 1)) + (QB'(1) << (2 * B));
                take = t <= x_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vs_reg[j+1] <= 1'b0;
                else
                    vs_reg[j+1] <= v_in;
            end

            always_ff @(posedge clk)
            begin
                rgn_s_reg[j+1]  <= rgn_in;
                zero_s_reg[j+1] <= zero_in;
                ovf_s_reg[j+1]  <= ovf_in;
                x_s_reg[j+1]    <= take ? x_in - t : x_in;
                r_s_reg[j+1]    <= take ? (r_in | (DIST_BITS'(1) << B)) : r_in;
            end
        end
    endgenerate

    assign busy        = 1'b0;
    assign done        = vs_reg[DIST_BITS];
    assign region      = rgn_s_reg[DIST_BITS];
    assign zero_length = zero_s_reg[DIST_BITS];
    // saturate when the root would not fit
    assign distance    = ovf_s_reg[DIST_BITS] ? '1 : r_s_reg[DIST_BITS];

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("accepted word did not complete on time");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without an accepted word");
    a_zero_region: assert property (@(posedge clk) disable iff (!rst_n)
        (done && zero_length) |-> (region == REGION_START))
        else $error("zero-length segment outside start region");
    a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (region == REGION_START || region == REGION_INTERIOR
                  || region == REGION_END))
        else $error("illegal region code");
`endif

endmodule
